// ----- sv/gcsn_pkg.sv -----
// Shared constants, payload types and helpers of the glyph crop-and-scale block.
`timescale 1ns / 1ps

package gcsn_pkg;

    localparam int MAX_SIDE    = 256;
    localparam int CANVAS_SIDE = 64;
    localparam int FIT_SIDE    = 56;

    localparam int SIDE_W      = $clog2(MAX_SIDE);       // source coordinate
    localparam int LEN_W       = SIDE_W + 1;             // side length up to MAX_SIDE
    localparam int ADDR_W      = 2 * SIDE_W;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int CANVAS_W    = $clog2(CANVAS_SIDE);
    localparam int FIT_W       = $clog2(FIT_SIDE + 1);
    localparam int GRAY_W      = 8;
    localparam int SUM_W       = 15;                     // 30R + 59G + 11B
    localparam int REM_W       = 14;                     // crop * FIT_SIDE
    localparam int NUM_W       = 15;                     // 2 * p * L + FIT_SIDE
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 2;

    localparam int GRAY_R_WT   = 30;
    localparam int GRAY_G_WT   = 59;
    localparam int GRAY_B_WT   = 11;

    // x / 100 == (x * 5243) >> 19 for x up to 25500.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_W     = SUM_W + 13;
    // x / 7 == (x * 2341) >> 14 for x up to 2047; x / 112 is (x >> 4) / 7.
    localparam int DIV7_MUL     = 2341;
    localparam int DIV7_SHIFT   = 14;
    localparam int DIV7_PRE     = 4;
    localparam int DIV7_W       = (NUM_W - DIV7_PRE) + 12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH     = CFG_DATA_W'(64);
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT    = CFG_DATA_W'(64);
    localparam logic [GRAY_W-1:0]     RST_THRESHOLD = GRAY_W'(220);
    localparam logic [GRAY_W-1:0]     INK_FULL      = GRAY_W'(255);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_INK_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_kind               kind;
        logic [31:0]         pixel;
        logic                first;
        logic [CANVAS_W-1:0] canvas_x;
        logic [CANVAS_W-1:0] canvas_y;
    } t_in;

    typedef struct packed {
        logic [GRAY_W-1:0] ink_value;
        logic              has_ink;
    } t_out;

    typedef struct packed {
        t_kind               kind;
        logic [GRAY_W-1:0]   gray;
        logic                first;
        logic [CANVAS_W-1:0] cx;
        logic [CANVAS_W-1:0] cy;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // A side register of 0 acts as 1, one above MAX_SIDE acts as MAX_SIDE.
    function automatic logic [LEN_W-1:0] eff_side(input logic [CFG_DATA_W-1:0] raw);
        logic [LEN_W-1:0] res;
        if (raw == '0) begin
            res = LEN_W'(1);
        end else if (raw > CFG_DATA_W'(MAX_SIDE)) begin
            res = LEN_W'(MAX_SIDE);
        end else begin
            res = LEN_W'(raw);
        end
        return res;
    endfunction

endpackage

// ----- sv/gcsn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gcsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/gcsn_front.sv -----
// Front end: accepts items, forms the weighted color sum and converts it to gray.
`timescale 1ns / 1ps

module gcsn_front import gcsn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in     i_in,
    input  t_q_stat i_q_stat,
    output logic    o_q_push,
    output t_cmd    o_q_cmd
);

    logic                r_stg_valid;
    t_kind               r_stg_kind;
    logic [SUM_W-1:0]    r_stg_sum;
    logic                r_stg_first;
    logic [CANVAS_W-1:0] r_stg_cx;
    logic [CANVAS_W-1:0] r_stg_cy;

    logic                accept;
    logic [SUM_W-1:0]    color_sum;
    logic [DIV100_W-1:0] gray_prod;

    assign o_in_stall = r_stg_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_stg_valid && !i_q_stat.full;

    assign color_sum = SUM_W'(i_in.pixel[23:16]) * SUM_W'(GRAY_R_WT)
                     + SUM_W'(i_in.pixel[15:8])  * SUM_W'(GRAY_G_WT)
                     + SUM_W'(i_in.pixel[7:0])   * SUM_W'(GRAY_B_WT);

    assign gray_prod = DIV100_W'(r_stg_sum) * DIV100_W'(DIV100_MUL);

    always_comb begin
        o_q_cmd.kind  = r_stg_kind;
        o_q_cmd.gray  = GRAY_W'(gray_prod >> DIV100_SHIFT);
        o_q_cmd.first = r_stg_first;
        o_q_cmd.cx    = r_stg_cx;
        o_q_cmd.cy    = r_stg_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (accept) begin
            r_stg_valid <= 1'b1;
        end else if (o_q_push) begin
            r_stg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_kind  <= i_in.kind;
            r_stg_sum   <= color_sum;
            r_stg_first <= i_in.first;
            r_stg_cx    <= i_in.canvas_x;
            r_stg_cy    <= i_in.canvas_y;
        end
    end

endmodule

// ----- sv/gcsn_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module gcsn_queue import gcsn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_push_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ----- sv/gcsn_back.sv -----
// Back end: stores gray pixels, tracks the ink box and samples the scaled canvas.
`timescale 1ns / 1ps

module gcsn_back import gcsn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_stat               i_q_stat,
    input  t_cmd                  i_q_head,
    output logic                  o_q_pop,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_PREP = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_QUO  = 7'b0010000,
        ST_ADDR = 7'b0100000,
        ST_RES  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [CFG_DATA_W-1:0] r_img_w;
    logic [CFG_DATA_W-1:0] r_img_h;
    logic [GRAY_W-1:0]     r_thr;

    logic [SIDE_W-1:0] r_left;
    logic [SIDE_W-1:0] r_right;
    logic [SIDE_W-1:0] r_top;
    logic [SIDE_W-1:0] r_bottom;
    logic              r_ink;
    logic [SIDE_W-1:0] r_col;
    logic [SIDE_W-1:0] r_row;

    // Scale cache: valid while no load has come in since it was computed.
    logic              r_dirty;
    logic [LEN_W-1:0]  r_long;
    logic [REM_W-1:0]  r_rem_w;
    logic [REM_W-1:0]  r_rem_h;
    logic [FIT_W-1:0]  r_qw;
    logic [FIT_W-1:0]  r_qh;
    logic [2:0]        r_step;

    logic [CANVAS_W-1:0] r_cx;
    logic [CANVAS_W-1:0] r_cy;
    logic [CANVAS_W-1:0] r_px;
    logic [CANVAS_W-1:0] r_py;
    logic                r_hit;
    logic [NUM_W-1:0]    r_nx;
    logic [NUM_W-1:0]    r_ny;
    logic [SIDE_W-1:0]   r_qx;
    logic [SIDE_W-1:0]   r_qy;

    logic r_out_valid;
    t_out r_out;

    logic [LEN_W-1:0]  lim_w;
    logic [LEN_W-1:0]  lim_h;
    logic [SIDE_W-1:0] lim_w_m1;
    logic [SIDE_W-1:0] lim_h_m1;

    logic              is_load;
    logic              is_read;
    logic [SIDE_W-1:0] ld_col;
    logic [SIDE_W-1:0] ld_row;
    logic [SIDE_W-1:0] base_left;
    logic [SIDE_W-1:0] base_right;
    logic [SIDE_W-1:0] base_top;
    logic [SIDE_W-1:0] base_bottom;
    logic              base_ink;
    logic              ink_px;

    logic [LEN_W-1:0]  crop_w;
    logic [LEN_W-1:0]  crop_h;
    logic [LEN_W-1:0]  long_len;
    logic [REM_W-1:0]  dsh;
    logic [FIT_W-1:0]  step_bit;
    logic [FIT_W-1:0]  new_w;
    logic [FIT_W-1:0]  new_h;
    logic [CANVAS_W-1:0] off_x;
    logic [CANVAS_W-1:0] off_y;
    logic [CANVAS_W-1:0] px;
    logic [CANVAS_W-1:0] py;
    logic                hit_x;
    logic                hit_y;
    logic [NUM_W-1:0]    prod_x;
    logic [NUM_W-1:0]    prod_y;
    logic [DIV7_W-1:0]   quo_x;
    logic [DIV7_W-1:0]   quo_y;
    logic [LEN_W-1:0]    s_x;
    logic [LEN_W-1:0]    s_y;
    logic [SIDE_W-1:0]   sx;
    logic [SIDE_W-1:0]   sy;
    logic                res_fire;

    logic              ram_we;
    logic              ram_re;
    logic [GRAY_W-1:0] ram_rdata;

    assign lim_w    = eff_side(r_img_w);
    assign lim_h    = eff_side(r_img_h);
    assign lim_w_m1 = SIDE_W'(lim_w - LEN_W'(1));
    assign lim_h_m1 = SIDE_W'(lim_h - LEN_W'(1));

    assign o_q_pop = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign is_load = o_q_pop && (i_q_head.kind == KIND_LOAD);
    assign is_read = o_q_pop && (i_q_head.kind == KIND_READ);

    // A first pixel restarts the image from the reset box and position.
    assign ld_col      = i_q_head.first ? '0 : r_col;
    assign ld_row      = i_q_head.first ? '0 : r_row;
    assign base_left   = i_q_head.first ? lim_w_m1 : r_left;
    assign base_right  = i_q_head.first ? '0 : r_right;
    assign base_top    = i_q_head.first ? lim_h_m1 : r_top;
    assign base_bottom = i_q_head.first ? '0 : r_bottom;
    assign base_ink    = i_q_head.first ? 1'b0 : r_ink;
    assign ink_px      = i_q_head.gray < r_thr;
    assign ram_we      = is_load;

    assign crop_w   = (r_right >= r_left) ? LEN_W'(r_right - r_left) + LEN_W'(1) : LEN_W'(1);
    assign crop_h   = (r_bottom >= r_top) ? LEN_W'(r_bottom - r_top) + LEN_W'(1) : LEN_W'(1);
    assign long_len = (crop_w >= crop_h) ? crop_w : crop_h;

    // Restoring division of crop * FIT_SIDE by the long side, one quotient bit a cycle.
    assign dsh      = REM_W'(r_long) << r_step;
    assign step_bit = FIT_W'(1) << r_step;
    assign new_w    = (r_qw == '0) ? FIT_W'(1) : r_qw;
    assign new_h    = (r_qh == '0) ? FIT_W'(1) : r_qh;

    assign off_x = CANVAS_W'((7'(CANVAS_SIDE) - 7'(new_w)) >> 1);
    assign off_y = CANVAS_W'((7'(CANVAS_SIDE) - 7'(new_h)) >> 1);
    assign px    = r_cx - off_x;
    assign py    = r_cy - off_y;
    assign hit_x = (r_cx >= off_x) && (FIT_W'(px) < new_w) && (px < CANVAS_W'(FIT_SIDE));
    assign hit_y = (r_cy >= off_y) && (FIT_W'(py) < new_h) && (py < CANVAS_W'(FIT_SIDE));

    assign prod_x = NUM_W'(r_px) * NUM_W'(r_long);
    assign prod_y = NUM_W'(r_py) * NUM_W'(r_long);
    assign quo_x  = DIV7_W'(r_nx >> DIV7_PRE) * DIV7_W'(DIV7_MUL);
    assign quo_y  = DIV7_W'(r_ny >> DIV7_PRE) * DIV7_W'(DIV7_MUL);

    assign s_x = LEN_W'(r_left) + LEN_W'(r_qx);
    assign s_y = LEN_W'(r_top) + LEN_W'(r_qy);
    assign sx  = (s_x >= lim_w) ? lim_w_m1 : SIDE_W'(s_x);
    assign sy  = (s_y >= lim_h) ? lim_h_m1 : SIDE_W'(s_y);

    assign ram_re   = (r_state == ST_ADDR);
    assign res_fire = (r_state == ST_RES) && (!r_out_valid || !i_out_stall);

    gcsn_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (STORE_DEPTH)
    ) u_gray_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({ld_row, ld_col}),
        .i_wdata (i_q_head.gray),
        .i_re    (ram_re),
        .i_raddr ({sy, sx}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_WIDTH;
            r_img_h <= RST_HEIGHT;
            r_thr   <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:   r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data;
                CFG_INK_THRESHOLD: r_thr   <= GRAY_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= SIDE_W'(RST_WIDTH - CFG_DATA_W'(1));
            r_right     <= '0;
            r_top       <= SIDE_W'(RST_HEIGHT - CFG_DATA_W'(1));
            r_bottom    <= '0;
            r_ink       <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_dirty     <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (is_load) begin
                        r_dirty <= 1'b1;
                        if (ink_px) begin
                            r_ink    <= 1'b1;
                            r_left   <= (ld_col < base_left)   ? ld_col : base_left;
                            r_right  <= (ld_col > base_right)  ? ld_col : base_right;
                            r_top    <= (ld_row < base_top)    ? ld_row : base_top;
                            r_bottom <= (ld_row > base_bottom) ? ld_row : base_bottom;
                        end else begin
                            r_ink    <= base_ink;
                            r_left   <= base_left;
                            r_right  <= base_right;
                            r_top    <= base_top;
                            r_bottom <= base_bottom;
                        end
                        if (LEN_W'(ld_col) + LEN_W'(1) >= lim_w) begin
                            r_col <= '0;
                            r_row <= (LEN_W'(ld_row) + LEN_W'(1) >= lim_h) ?
                                     '0 : ld_row + SIDE_W'(1);
                        end else begin
                            r_col <= ld_col + SIDE_W'(1);
                            r_row <= ld_row;
                        end
                    end else if (is_read) begin
                        if (r_dirty) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_dirty <= 1'b0;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_QUO;
                ST_QUO:  r_state <= ST_ADDR;
                ST_ADDR: r_state <= ST_RES;
                ST_RES: begin
                    if (res_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_cx <= i_q_head.cx;
            r_cy <= i_q_head.cy;
            if (r_dirty) begin
                r_long  <= long_len;
                r_rem_w <= REM_W'(crop_w) * REM_W'(FIT_SIDE);
                r_rem_h <= REM_W'(crop_h) * REM_W'(FIT_SIDE);
                r_qw    <= '0;
                r_qh    <= '0;
                r_step  <= 3'(FIT_W - 1);
            end
        end
        if (r_state == ST_DIV) begin
            if (r_rem_w >= dsh) begin
                r_rem_w <= r_rem_w - dsh;
                r_qw    <= r_qw | step_bit;
            end
            if (r_rem_h >= dsh) begin
                r_rem_h <= r_rem_h - dsh;
                r_qh    <= r_qh | step_bit;
            end
            r_step <= r_step - 3'd1;
        end
        if (r_state == ST_PREP) begin
            r_px  <= px;
            r_py  <= py;
            r_hit <= r_ink && hit_x && hit_y;
        end
        if (r_state == ST_MUL) begin
            r_nx <= (prod_x << 1) + NUM_W'(FIT_SIDE);
            r_ny <= (prod_y << 1) + NUM_W'(FIT_SIDE);
        end
        if (r_state == ST_QUO) begin
            r_qx <= SIDE_W'(quo_x >> DIV7_SHIFT);
            r_qy <= SIDE_W'(quo_y >> DIV7_SHIFT);
        end
        if (res_fire) begin
            r_out.ink_value <= r_hit ? INK_FULL - ram_rdata : '0;
            r_out.has_ink   <= r_ink;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- sv/glyph_crop_scale_normalize_top.sv -----
// Top level of the glyph crop-and-scale block: front end, command queue and back end.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall    i_in  (t_in)
//  out      output     o_out_valid / i_out_stall  o_out (t_out)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Load items are taken one per cycle unless the queue is full; the back end stores one
// gray pixel per cycle while idle. A read item passes the steps prepare, multiply,
// quotient, address and result; a long-side division leads the first read after a load.
// Reset is synchronous and active low; the gray store has no clearing pass.
// A stalled output holds the back end in its last step; the queue takes items until full.
`timescale 1ns / 1ps

module glyph_crop_scale_normalize_top import gcsn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_q_stat q_stat;
    logic    q_push;
    t_cmd    q_push_cmd;
    logic    q_pop;
    t_cmd    q_head;

    assign o_cfg_ready = 1'b1;

    gcsn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_stat   (q_stat),
        .o_q_push   (q_push),
        .o_q_cmd    (q_push_cmd)
    );

    gcsn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_stat     (q_stat)
    );

    gcsn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTH
    // Ink can only be reported for an image in which ink was found.
    a_ink_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.has_ink || (o_out.ink_value == '0)))
        else $error("ink value reported without any ink in the image");

    // The queue cannot report full and empty together.
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // Right after reset the front end takes items.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("input stalled right after reset");

    // Nothing is pushed into the queue while it is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !q_push)
        else $error("push into a full queue");
`endif

endmodule
